### rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the triangle circumcircle block.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Corner coordinate width (unsigned integer pixels)
  localparam int COORD_BITS = 12;
  // Default number of fraction bits on the results
  localparam int FRAC_BITS_DEF = 8;
  // Result field width
  localparam int OUT_W = 24;
  // Radius square quotient is capped at 2^YCAP_SHIFT, the first value that
  // always clips the radius
  localparam int YCAP_SHIFT = 2 * (OUT_W + 1);
  // Root bits produced by the square root pipe
  localparam int SQ_W = YCAP_SHIFT / 2;

  // One input beat: the three corners
  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by_coord;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
  } corners_t;

  // One result beat
  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        circle_radius;
    logic                    degenerate;
    logic                    saturated;
  } result_t;

endpackage

### rtl/triangle_circumcircle.sv
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Center and radius of the circle through three corners, fixed point.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle may be started every cycle and busy is low
// except during reset. Each result appears with done high, in start order;
// the depth is set by the front stages, the bit-per-stage dividers, the
// bit-per-stage square root and the output register. Results are not held:
// the receiver must take each beat in the cycle done is high. Collinear
// corners give zeros with degenerate set; clipped values set saturated.
module triangle_circumcircle
  import tcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  corners_t corners,
  output logic     done,
  output result_t  result
);

  localparam int C      = COORD_BITS;
  localparam int DIF_W  = C + 1;
  localparam int PR_W   = 2 * C + 2;
  localparam int DD_W   = 2 * C + 3;
  localparam int SQL_W  = 2 * C + 1;
  localparam int DA_W   = 2 * C + 2;
  localparam int M_W    = 3 * C + 4;
  localparam int NUM_W  = 3 * C + 5;
  localparam int MAG_W  = 3 * C + 4;
  localparam int QC     = MAG_W + FRAC_BITS + 2;
  localparam int DQ     = (QC > YCAP_SHIFT) ? QC : YCAP_SHIFT;
  localparam int DEN_W  = DA_W + 2;
  localparam int LAB_W  = 2 * SQL_W;
  localparam int PP_W   = 2 * SQL_W;
  localparam int WN_W   = 3 * SQL_W + 2 * FRAC_BITS;
  localparam int WD_W   = 2 * DA_W;
  localparam int TW     = DQ + 2;
  localparam int LAT    = 8 + DQ + SQ_W;

  localparam logic signed [TW-1:0] SMAX = TW'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [TW-1:0] SMIN = -SMAX - TW'(1);
  localparam logic [SQ_W-1:0]      UMAX = SQ_W'((2 ** OUT_W) - 1);

  typedef struct packed {
    logic          neg;
    logic [C-1:0]  base;
  } ctag_t;

  typedef struct packed {
    logic deg;
    logic cap;
  } rtag_t;

  typedef struct packed {
    logic [DQ-1:0] qx;
    ctag_t         tx;
    logic [DQ-1:0] qy;
    ctag_t         ty;
    rtag_t         tr;
  } stag_t;

  logic [LAT-1:0] vp;
  logic           accept;

  assign busy   = rst;
  assign accept = start & ~busy;

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[LAT-2:0], accept};
    end
  end

  assign done = vp[LAT-1];

  // Stage 1: edge vectors
  logic signed [DIF_W-1:0] ux1, uy1, vx1, vy1, wx1, wy1;
  logic [C-1:0]            x01, y01;

  always_ff @(posedge clk) begin
    ux1 <= $signed(DIF_W'(corners.bx))       - $signed(DIF_W'(corners.ax));
    uy1 <= $signed(DIF_W'(corners.by_coord)) - $signed(DIF_W'(corners.ay));
    vx1 <= $signed(DIF_W'(corners.cx))       - $signed(DIF_W'(corners.bx));
    vy1 <= $signed(DIF_W'(corners.cy))       - $signed(DIF_W'(corners.by_coord));
    wx1 <= $signed(DIF_W'(corners.ax))       - $signed(DIF_W'(corners.cx));
    wy1 <= $signed(DIF_W'(corners.ay))       - $signed(DIF_W'(corners.cy));
    x01 <= corners.ax;
    y01 <= corners.ay;
  end

  // Stage 2: cross and dot products, squared edge components
  logic signed [PR_W-1:0]  pd1, pd2, pn1, pn2;
  logic signed [PR_W-1:0]  sux, suy, svx, svy, swx, swy;
  logic signed [DIF_W-1:0] ux2, uy2;
  logic [C-1:0]            x02, y02;

  always_ff @(posedge clk) begin
    pd1 <= PR_W'(ux1) * PR_W'(wy1);
    pd2 <= PR_W'(uy1) * PR_W'(wx1);
    pn1 <= PR_W'(vx1) * PR_W'(wx1);
    pn2 <= PR_W'(vy1) * PR_W'(wy1);
    sux <= PR_W'(ux1) * PR_W'(ux1);
    suy <= PR_W'(uy1) * PR_W'(uy1);
    svx <= PR_W'(vx1) * PR_W'(vx1);
    svy <= PR_W'(vy1) * PR_W'(vy1);
    swx <= PR_W'(wx1) * PR_W'(wx1);
    swy <= PR_W'(wy1) * PR_W'(wy1);
    ux2 <= ux1;
    uy2 <= uy1;
    x02 <= x01;
    y02 <= y01;
  end

  // Stage 3: D, N and the three squared lengths
  logic signed [DD_W-1:0]  dd3, nn3;
  logic [SQL_W-1:0]        la3, lb3, lc3;
  logic signed [DIF_W-1:0] ux3, uy3;
  logic [C-1:0]            x03, y03;

  always_ff @(posedge clk) begin
    dd3 <= DD_W'(pd1) - DD_W'(pd2);
    nn3 <= DD_W'(pn1) + DD_W'(pn2);
    la3 <= SQL_W'(sux + suy);
    lb3 <= SQL_W'(svx + svy);
    lc3 <= SQL_W'(swx + swy);
    ux3 <= ux2;
    uy3 <= uy2;
    x03 <= x02;
    y03 <= y02;
  end

  // Stage 4: center numerator products, |D|, la*lb
  logic signed [M_W-1:0] m1, m2, m3, m4;
  logic [DA_W-1:0]       dabs4;
  logic                  dneg4, deg4;
  logic [LAB_W-1:0]      lab4;
  logic [SQL_W-1:0]      lc4;
  logic [C-1:0]          x04, y04;

  always_ff @(posedge clk) begin
    m1    <= M_W'(ux3) * M_W'(dd3);
    m2    <= M_W'(nn3) * M_W'(uy3);
    m3    <= M_W'(uy3) * M_W'(dd3);
    m4    <= M_W'(nn3) * M_W'(ux3);
    dabs4 <= DA_W'(dd3[DD_W-1] ? -dd3 : dd3);
    dneg4 <= dd3[DD_W-1];
    deg4  <= (dd3 == '0);
    lab4  <= LAB_W'(la3) * LAB_W'(lb3);
    lc4   <= lc3;
    x04   <= x03;
    y04   <= y03;
  end

  // Stage 5: center numerators, D squared, partial products of la*lb*lc
  logic signed [NUM_W-1:0] numx5, numy5;
  logic [WD_W-1:0]         dsq5;
  logic [PP_W-1:0]         pl5, ph5;
  logic [DA_W-1:0]         dabs5;
  logic                    dneg5, deg5;
  logic [C-1:0]            x05, y05;

  always_ff @(posedge clk) begin
    numx5 <= NUM_W'(m1) - NUM_W'(m2);
    numy5 <= NUM_W'(m3) + NUM_W'(m4);
    dsq5  <= WD_W'(dabs4) * WD_W'(dabs4);
    pl5   <= PP_W'(lab4[SQL_W-1:0]) * PP_W'(lc4);
    ph5   <= PP_W'(lab4[LAB_W-1:SQL_W]) * PP_W'(lc4);
    dabs5 <= dabs4;
    dneg5 <= dneg4;
    deg5  <= deg4;
    x05   <= x04;
    y05   <= y04;
  end

  // Stage 6: rounded center dividends, radius dividend
  logic [QC-1:0]    ncx6, ncy6;
  logic [DEN_W-1:0] den6;
  logic [WN_W-1:0]  wn6;
  logic [WD_W-1:0]  wd6;
  ctag_t            tx6, ty6;
  logic             deg6;
  logic [MAG_W-1:0] magx, magy;
  logic [WN_W-1:0]  wsum;

  always_comb begin
    magx = MAG_W'(numx5[NUM_W-1] ? -numx5 : numx5);
    magy = MAG_W'(numy5[NUM_W-1] ? -numy5 : numy5);
    wsum = (WN_W'(ph5) << SQL_W) + WN_W'(pl5);
  end

  always_ff @(posedge clk) begin
    ncx6    <= (QC'(magx) << (FRAC_BITS + 1)) + QC'({dabs5, 1'b0});
    ncy6    <= (QC'(magy) << (FRAC_BITS + 1)) + QC'({dabs5, 1'b0});
    den6    <= {dabs5, 2'b00};
    wn6     <= wsum << (2 * FRAC_BITS);
    wd6     <= dsq5;
    tx6.neg <= numx5[NUM_W-1] ^ dneg5;
    tx6.base <= x05;
    ty6.neg <= numy5[NUM_W-1] ^ dneg5;
    ty6.base <= y05;
    deg6    <= deg5;
  end

  // Stage 7: detect the radius cap and drop a capped dividend
  logic [QC-1:0]    ncx7, ncy7;
  logic [DEN_W-1:0] den7;
  logic [WN_W-1:0]  wn7;
  logic [WD_W-1:0]  wd7;
  ctag_t            tx7, ty7;
  rtag_t            tr7;
  logic             cap6;

  assign cap6 = ((wn6 >> YCAP_SHIFT) >= WN_W'(wd6));

  always_ff @(posedge clk) begin
    ncx7    <= ncx6;
    ncy7    <= ncy6;
    den7    <= den6;
    wn7     <= cap6 ? '0 : wn6;
    wd7     <= wd6;
    tx7     <= tx6;
    ty7     <= ty6;
    tr7.deg <= deg6;
    tr7.cap <= cap6;
  end

  // Dividers: center offsets and the radius square quotient
  logic [DQ-1:0] qx, qy, qr;
  ctag_t         txd, tyd;
  rtag_t         trd, trd_o;

  tcc_div #(.N_W(QC), .D_W(DEN_W), .Q_W(DQ), .T_W($bits(ctag_t))) u_div_x (
    .clk     (clk),
    .num     (ncx7),
    .den     (den7),
    .tag     (tx7),
    .quo     (qx),
    .tag_out (txd)
  );

  tcc_div #(.N_W(QC), .D_W(DEN_W), .Q_W(DQ), .T_W($bits(ctag_t))) u_div_y (
    .clk     (clk),
    .num     (ncy7),
    .den     (den7),
    .tag     (ty7),
    .quo     (qy),
    .tag_out (tyd)
  );

  tcc_div #(.N_W(WN_W), .D_W(WD_W), .Q_W(DQ), .T_W($bits(rtag_t))) u_div_r (
    .clk     (clk),
    .num     (wn7),
    .den     (wd7),
    .tag     (trd),
    .quo     (qr),
    .tag_out (trd_o)
  );

  assign trd = tr7;

  // Square root of the capped quotient, center values ride along
  stag_t          sin, sout;
  logic [SQ_W-1:0] root;

  always_comb begin
    sin.qx = qx;
    sin.tx = txd;
    sin.qy = qy;
    sin.ty = tyd;
    sin.tr = trd_o;
  end

  tcc_sqrt #(.R_W(SQ_W), .T_W($bits(stag_t))) u_sqrt (
    .clk     (clk),
    .y       (qr[YCAP_SHIFT-1:0]),
    .tag     (sin),
    .root    (root),
    .tag_out (sout)
  );

  // Output stage: add the base, round the radius, clip
  logic signed [TW-1:0] totx, toty;
  logic [SQ_W:0]        rsum;
  logic [SQ_W-1:0]      rfull;
  result_t              res_next;

  always_comb begin
    totx  = sout.tx.neg ? $signed(TW'({sout.tx.base, {FRAC_BITS{1'b0}}}) - TW'(sout.qx))
                        : $signed(TW'({sout.tx.base, {FRAC_BITS{1'b0}}}) + TW'(sout.qx));
    toty  = sout.ty.neg ? $signed(TW'({sout.ty.base, {FRAC_BITS{1'b0}}}) - TW'(sout.qy))
                        : $signed(TW'({sout.ty.base, {FRAC_BITS{1'b0}}}) + TW'(sout.qy));
    rsum  = (SQ_W + 1)'(root) + (SQ_W + 1)'(1);
    rfull = rsum[SQ_W:1];
    res_next = '0;
    if (sout.tr.deg) begin
      res_next.degenerate = 1'b1;
    end else begin
      if (totx > SMAX) begin
        res_next.center_x  = OUT_W'(SMAX);
        res_next.saturated = 1'b1;
      end else if (totx < SMIN) begin
        res_next.center_x  = OUT_W'(SMIN);
        res_next.saturated = 1'b1;
      end else begin
        res_next.center_x = OUT_W'(totx);
      end
      if (toty > SMAX) begin
        res_next.center_y  = OUT_W'(SMAX);
        res_next.saturated = 1'b1;
      end else if (toty < SMIN) begin
        res_next.center_y  = OUT_W'(SMIN);
        res_next.saturated = 1'b1;
      end else begin
        res_next.center_y = OUT_W'(toty);
      end
      if (sout.tr.cap || (rfull > UMAX)) begin
        res_next.circle_radius = OUT_W'(UMAX);
        res_next.saturated     = 1'b1;
      end else begin
        res_next.circle_radius = OUT_W'(rfull);
      end
    end
  end

  // Hold the result beat for its one cycle
  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

### rtl/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider, one quotient bit per stage. The numerator
// shifted right by Q_W must be below the divisor. A tag rides alongside.
// ----------------------------------------------------------------------------
module tcc_div
  import tcc_pkg::*;
#(
  parameter int N_W = 50,
  parameter int D_W = 28,
  parameter int Q_W = 50,
  parameter int T_W = 1
) (
  input  logic           clk,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  input  logic [T_W-1:0] tag,
  output logic [Q_W-1:0] quo,
  output logic [T_W-1:0] tag_out
);

  logic [D_W-1:0] rem [Q_W+1];
  logic [D_W-1:0] dsr [Q_W+1];
  logic [Q_W-1:0] nq  [Q_W+1];
  logic [T_W-1:0] tg  [Q_W+1];

  // Load the leading partial remainder and the numerator bits still to come
  assign rem[0] = D_W'(num >> Q_W);
  assign nq[0]  = Q_W'(num);
  assign dsr[0] = den;
  assign tg[0]  = tag;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         qb;

    // Bring down one numerator bit and try the subtract
    always_comb begin
      trial = {rem[k], nq[k][Q_W-1]};
      diff  = trial - {1'b0, dsr[k]};
      qb    = (trial >= {1'b0, dsr[k]});
    end

    // Advance remainder, quotient and tag
    always_ff @(posedge clk) begin
      rem[k+1] <= qb ? diff[D_W-1:0] : trial[D_W-1:0];
      nq[k+1]  <= {nq[k][Q_W-2:0], qb};
      dsr[k+1] <= dsr[k];
      tg[k+1]  <= tg[k];
    end
  end

  assign quo     = nq[Q_W];
  assign tag_out = tg[Q_W];

endmodule

### rtl/tcc_sqrt.sv
// ----------------------------------------------------------------------------
// tcc_sqrt
// Pipelined integer square root, one root bit per stage (floor of root).
// A tag rides alongside.
// ----------------------------------------------------------------------------
module tcc_sqrt
  import tcc_pkg::*;
#(
  parameter int R_W = 25,
  parameter int T_W = 1
) (
  input  logic             clk,
  input  logic [2*R_W-1:0] y,
  input  logic [T_W-1:0]   tag,
  output logic [R_W-1:0]   root,
  output logic [T_W-1:0]   tag_out
);

  logic [R_W+1:0]   rem [R_W+1];
  logic [R_W-1:0]   rt  [R_W+1];
  logic [2*R_W-1:0] ys  [R_W+1];
  logic [T_W-1:0]   tg  [R_W+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign ys[0]  = y;
  assign tg[0]  = tag;

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [R_W+3:0] trial;
    logic [R_W+3:0] tst;
    logic [R_W+3:0] diff;
    logic           ge;

    // Bring down two radicand bits and test root*4+1
    always_comb begin
      trial = {rem[k], ys[k][2*R_W-1 -: 2]};
      tst   = (R_W+4)'({rt[k], 2'b01});
      diff  = trial - tst;
      ge    = (trial >= tst);
    end

    // Advance remainder, root and tag
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[R_W+1:0] : trial[R_W+1:0];
      rt[k+1]  <= {rt[k][R_W-2:0], ge};
      ys[k+1]  <= {ys[k][2*R_W-3:0], 2'b00};
      tg[k+1]  <= tg[k];
    end
  end

  assign root    = rt[R_W];
  assign tag_out = tg[R_W];

endmodule

### rtl/tcc_chk.sv
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks of the circumcircle block, attached by bind.
// ----------------------------------------------------------------------------
module tcc_chk
  import tcc_pkg::*;
#(
  parameter int LAT = 83
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input corners_t corners,
  input logic     done,
  input result_t  result
);

  // No beat comes out right after reset
  a_quiet_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("done raised right after reset");

  // Every result beat answers a start accepted a fixed latency earlier
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without a matching start");

  // Coincident corners come back degenerate
  a_point_degenerate: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && corners.ax == corners.bx && corners.ax == corners.cx &&
     corners.ay == corners.by_coord && corners.ay == corners.cy)
    |-> ##LAT (done && result.degenerate))
    else $error("coincident corners not flagged degenerate");

  // A degenerate beat carries zeros and no clip flag
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.degenerate) |->
    (result.center_x == '0 && result.center_y == '0 &&
     result.circle_radius == '0 && !result.saturated))
    else $error("degenerate beat with nonzero fields");

endmodule

bind triangle_circumcircle tcc_chk #(.LAT(LAT)) u_tcc_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .corners (corners),
  .done    (done),
  .result  (result)
);

### dv/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Watches the corner and result channels of the circumcircle block, predicts
// each result from the accepted corners in exact integer arithmetic and
// compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tcc_checker
  import tcc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  corners_t corners,
  input  logic     done,
  input  result_t  result,
  output int       fail_count,
  output int       pending
);

  result_t circle_q[$];

  // Round base + num/den to fixed point and clip, den > 0, neg gives the sign.
  function automatic longint place_center(longint base, logic [127:0] mag, bit neg,
                                          logic [127:0] den, ref bit sat);
    logic [127:0] q, r, f, rem, off;
    longint total;
    q = mag / den;
    r = mag % den;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    f = (r << FRAC_BITS) / den;
    rem = (r << FRAC_BITS) % den;
    if (2 * rem >= den) f = f + 1;
    off = (q << FRAC_BITS) + f;
    total = base * (64'sd1 << FRAC_BITS);
    total = neg ? total - longint'(off) : total + longint'(off);
    if (total > 8388607) begin
      sat = 1;
      total = 8388607;
    end
    if (total < -8388608) begin
      sat = 1;
      total = -8388608;
    end
    return total;
  endfunction

  // Integer square root, floor.
  function automatic logic [127:0] root_floor(logic [127:0] y);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 62;
    while (bitv > y) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (y >= res + bitv) begin
        y = y - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic result_t circumcircle(corners_t c);
    longint x0, y0, x1, y1, x2, y2, ux, uy, vx, vy, wx, wy, dd, nn, numx, numy;
    logic [127:0] dabs, den, la, lb, lc, wn, wd, yv, rad;
    bit sat;
    result_t r;
    x0 = longint'(c.ax); y0 = longint'(c.ay);
    x1 = longint'(c.bx); y1 = longint'(c.by_coord);
    x2 = longint'(c.cx); y2 = longint'(c.cy);
    ux = x1 - x0; uy = y1 - y0;
    vx = x2 - x1; vy = y2 - y1;
    wx = x0 - x2; wy = y0 - y2;
    dd = ux * wy - uy * wx;
    nn = vx * wx + vy * wy;
    r = '0;
    sat = 0;
    if (dd == 0) begin
      r.degenerate = 1;
      return r;
    end
    dabs = 128'(dd < 0 ? -dd : dd);
    den = 2 * dabs;
    numx = ux * dd - nn * uy;
    numy = uy * dd + nn * ux;
    r.center_x = OUT_W'(place_center(x0, 128'(numx < 0 ? -numx : numx),
                                     (numx < 0) != (dd < 0), den, sat));
    r.center_y = OUT_W'(place_center(y0, 128'(numy < 0 ? -numy : numy),
                                     (numy < 0) != (dd < 0), den, sat));
    la = 128'(ux * ux + uy * uy);
    lb = 128'(vx * vx + vy * vy);
    lc = 128'(wx * wx + wy * wy);
    // products stay below 2^128: 3*25 bits + 16 fraction bits
    wn = (la * lb * lc) << (2 * FRAC_BITS);
    wd = dabs * dabs;
    if (wn >= (wd << YCAP_SHIFT)) yv = 128'd1 << YCAP_SHIFT;
    else yv = wn / wd;
    rad = (root_floor(yv) + 1) >> 1;
    if (rad > 16777215) begin
      sat = 1;
      rad = 16777215;
    end
    r.circle_radius = rad[23:0];
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Predict on each accepted corner beat, compare on each result beat.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (circle_q.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = circle_q.pop_front();
          if (result.center_x !== want.center_x)
            report_mismatch("center_x", result.center_x, want.center_x);
          if (result.center_y !== want.center_y)
            report_mismatch("center_y", result.center_y, want.center_y);
          if (result.circle_radius !== want.circle_radius)
            report_mismatch("circle_radius", result.circle_radius, want.circle_radius);
          if (result.degenerate !== want.degenerate)
            report_mismatch("degenerate", result.degenerate, want.degenerate);
          if (result.saturated !== want.saturated)
            report_mismatch("saturated", result.saturated, want.saturated);
        end
      end
      if (start && !busy) circle_q.push_back(circumcircle(corners));
    end
    pending = circle_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

### dv/tb_triangle_circumcircle.sv
// ----------------------------------------------------------------------------
// tb_triangle_circumcircle
// Drives directed and random triangles into the circumcircle block with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_triangle_circumcircle;
  import tcc_pkg::*;

  localparam int LIMIT = 200000;
  localparam int DRAIN = 120;

  logic     clk = 0;
  logic     rst = 1;
  logic     start = 0;
  logic     busy;
  corners_t corners = '0;
  logic     done;
  result_t  result;
  int       fail_count, pending, cycles;

  triangle_circumcircle u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corners(corners), .done(done), .result(result)
  );

  tcc_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .corners(corners),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
  initial cycles = 0;

  function automatic logic [11:0] pick_coord(int mode);
    case (mode)
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom_range(0, 15));
      default: return 12'($urandom);
    endcase
  endfunction

  // Hold one beat until accepted, then drop start for an optional random gap.
  task automatic send_beat(corners_t c);
    int gap;
    start <= 1;
    corners <= c;
    do @(posedge clk); while (busy);
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      start <= 0;
      corners <= corners_t'($bits(corners_t)'({$urandom, $urandom, $urandom}));
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic corners_t tri_of(int x0, int y0, int x1, int y1, int x2, int y2);
    corners_t c;
    c.ax = COORD_BITS'(x0); c.ay = COORD_BITS'(y0);
    c.bx = COORD_BITS'(x1); c.by_coord = COORD_BITS'(y1);
    c.cx = COORD_BITS'(x2); c.cy = COORD_BITS'(y2);
    return c;
  endfunction

  initial begin
    corners_t c;
    int m;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Extremes, right angles, collinear, coincident, slivers.
    send_beat(tri_of(0, 0, 0, 0, 0, 0));
    send_beat(tri_of(4095, 4095, 4095, 4095, 4095, 4095));
    send_beat(tri_of(0, 0, 4095, 0, 0, 4095));
    send_beat(tri_of(4095, 4095, 0, 4095, 4095, 0));
    send_beat(tri_of(0, 0, 4095, 4095, 2000, 2000));
    send_beat(tri_of(0, 0, 1, 0, 0, 1));
    send_beat(tri_of(0, 0, 4095, 1, 4094, 1));
    send_beat(tri_of(0, 0, 4095, 0, 2048, 1));
    send_beat(tri_of(0, 4095, 4095, 4094, 1, 4095));
    send_beat(tri_of(10, 10, 10, 10, 20, 30));
    send_beat(tri_of(0, 0, 2, 0, 1, 1));
    send_beat(tri_of(5, 7, 5, 300, 5, 4000));
    send_beat(tri_of(0, 0, 4095, 0, 4095, 4095));
    send_beat(tri_of(1, 2, 3, 5, 4095, 4094));
    send_beat(tri_of(2730, 1365, 1365, 2730, 4095, 4095));
    // Random triangles, mixed scales; some near-collinear slivers.
    for (int i = 0; i < 750; i++) begin
      m = $urandom_range(0, 9);
      c = tri_of(pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                 pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                 pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)));
      if (m < 5) c = corners_t'($bits(corners_t)'({$urandom, $urandom, $urandom}));
      else if (m == 5) begin
        c.cx = COORD_BITS'(c.ax + 2 * (c.bx - c.ax));
        c.cy = COORD_BITS'(c.ay + 2 * (c.by_coord - c.ay) + $urandom_range(0, 1));
      end
      send_beat(c);
    end
    start <= 0;
    while (pending > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
